FILE: design/cdg_pkg.sv
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared types and constants of the greedy cash dispenser: request and
// response beat layouts, status and function codes, and note value tables.
// ----------------------------------------------------------------------------
package cdg_pkg;

   localparam int NUM_DENOMS = 6;
   localparam int IDX_W      = 3;
   localparam int CNT_W      = 10;
   localparam int AMT_W      = 23;
   localparam int QUOT_W     = 17;
   localparam int NOTE_W     = 13;
   localparam int RECIP_W    = 30;
   localparam int PROD_W     = AMT_W + RECIP_W;
   localparam int ACC_W      = AMT_W + 1;

   // Reciprocals are scaled so that every quotient comes from the same
   // right shift of the product.
   localparam int RECIP_SHIFT = 36;

   localparam logic [15:0]      MAX_NOTES = 16'd1000;
   localparam logic [AMT_W-1:0] TOTAL_MAX = 23'h7FFFFF;

   localparam logic FUNC_WITHDRAW = 1'b0;
   localparam logic FUNC_LOAD     = 1'b1;

   localparam logic [2:0] STAT_DISPENSED   = 3'd0;
   localparam logic [2:0] STAT_BELOW_MIN   = 3'd1;
   localparam logic [2:0] STAT_NOT_MULT    = 3'd2;
   localparam logic [2:0] STAT_OVER_TOTAL  = 3'd3;
   localparam logic [2:0] STAT_NO_COMPOSE  = 3'd4;
   localparam logic [2:0] STAT_LOADED      = 3'd5;

   // Index 0 is the 100 note, index 5 the 5000 note.
   localparam logic [NOTE_W-1:0] NOTE_VALUE [NUM_DENOMS] = '{
      13'd100, 13'd200, 13'd500, 13'd1000, 13'd2000, 13'd5000
   };

   // ceil(2^s / v) shifted up to a common shift of RECIP_SHIFT; exact floor
   // division for every 23-bit dividend.
   localparam logic [RECIP_W-1:0] NOTE_RECIP [NUM_DENOMS] = '{
      30'd687194816, 30'd343597408, 30'd137438960,
      30'd68719480,  30'd34359740,  30'd13743896
   };

   typedef struct packed {
      logic             func;
      logic [AMT_W-1:0] amount;
      logic [IDX_W-1:0] denom_index;
      logic [CNT_W-1:0] load_count;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [CNT_W-1:0] give_5000;
      logic [CNT_W-1:0] give_2000;
      logic [CNT_W-1:0] give_1000;
      logic [CNT_W-1:0] give_500;
      logic [CNT_W-1:0] give_200;
      logic [CNT_W-1:0] give_100;
      logic [AMT_W-1:0] total_after;
   } rsp_type;

endpackage

FILE: design/cdg_channels.sv
// ----------------------------------------------------------------------------
// cdg_channels
// Valid/ready channels of the cash dispenser: one for request beats and one
// for response beats.
// ----------------------------------------------------------------------------
interface cdg_req_if import cdg_pkg::*;;
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cdg_rsp_if import cdg_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/cash_dispense_greedy_top.sv
// ----------------------------------------------------------------------------
// cash_dispense_greedy_top
// Note stock keeper and greedy withdrawal splitter for six note values.
// ----------------------------------------------------------------------------
// One request beat is worked on at a time, and all arithmetic goes through a
// single 23x30 multiplier under a small sequencer, one use per cycle. From the
// accept until the block can take the next beat, a dispensed withdrawal goes
// through two check steps, a divide and a subtract step per note value, one
// debit step, a sum step per note value to add up the stock value, and a step
// to post the response. A rejected withdrawal posts after the checks or the
// split, a load after the sum steps, and a load with a note index above 5
// posts straight away. The result is held in an output register, so a new
// beat is taken while the previous response still waits; the block only
// stalls when it has a second response ready before the first is taken.
// ----------------------------------------------------------------------------
module cash_dispense_greedy_top import cdg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdg_req_if.sink   req_chan,
   cdg_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_DIV,
      ST_CHK_MUL,
      ST_SPL_DIV,
      ST_SPL_SUB,
      ST_DEBIT,
      ST_SUM,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [AMT_W-1:0] amount_ff, amount_in;
   logic [AMT_W-1:0] rest_ff, rest_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [2:0]       status_ff, status_in;
   logic [CNT_W-1:0] take_ff [NUM_DENOMS];
   logic [CNT_W-1:0] take_in [NUM_DENOMS];
   logic [CNT_W-1:0] stock_ff [NUM_DENOMS];
   logic [CNT_W-1:0] stock_in [NUM_DENOMS];
   logic [AMT_W-1:0] total_ff, total_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [AMT_W-1:0]   mul_a;
   logic [RECIP_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;
   logic [CNT_W-1:0]   take_n;
   logic [CNT_W-1:0]   cnt_sat;
   logic [AMT_W-1:0]   rest_next;
   logic [ACC_W-1:0]   acc_sum;
   logic               dispensed;

   // The shared multiplier.
   assign prod = {{RECIP_W{1'b0}}, mul_a} * {{AMT_W{1'b0}}, mul_b};

   // The greedy take is the quotient, capped by the notes in stock.
   assign take_n = (quot_ff > QUOT_W'(stock_ff[idx_ff])) ? stock_ff[idx_ff]
                                                        : quot_ff[CNT_W-1:0];
   assign cnt_sat = ({6'b0, req_chan.data.load_count} > MAX_NOTES)
                    ? MAX_NOTES[CNT_W-1:0] : req_chan.data.load_count;
   assign rest_next = rest_ff - prod[AMT_W-1:0];
   assign acc_sum   = acc_ff + prod[ACC_W-1:0];
   assign dispensed = (status_ff == STAT_DISPENSED);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      amount_in    = amount_ff;
      rest_in      = rest_ff;
      quot_in      = quot_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      take_in      = take_ff;
      stock_in     = stock_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.data.func == FUNC_LOAD) begin
                  status_in = STAT_LOADED;
                  if (req_chan.data.denom_index < IDX_W'(NUM_DENOMS)) begin
                     stock_in[req_chan.data.denom_index] = cnt_sat;
                     idx_in   = '0;
                     acc_in   = '0;
                     state_in = ST_SUM;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  amount_in = req_chan.data.amount;
                  state_in  = ST_CHK_DIV;
               end
            end
         end
         ST_CHK_DIV: begin
            mul_a    = amount_ff;
            mul_b    = NOTE_RECIP[0];
            quot_in  = prod[RECIP_SHIFT +: QUOT_W];
            state_in = ST_CHK_MUL;
         end
         ST_CHK_MUL: begin
            // The amount is a multiple of 100 when the quotient multiplies
            // back to it exactly.
            mul_a = AMT_W'(quot_ff);
            mul_b = RECIP_W'(NOTE_VALUE[0]);
            if (amount_ff < AMT_W'(NOTE_VALUE[0])) begin
               status_in = STAT_BELOW_MIN;
               state_in  = ST_FINISH;
            end else if (prod != PROD_W'(amount_ff)) begin
               status_in = STAT_NOT_MULT;
               state_in  = ST_FINISH;
            end else if (amount_ff > total_ff) begin
               status_in = STAT_OVER_TOTAL;
               state_in  = ST_FINISH;
            end else begin
               rest_in  = amount_ff;
               idx_in   = IDX_W'(NUM_DENOMS - 1);
               state_in = ST_SPL_DIV;
            end
         end
         ST_SPL_DIV: begin
            mul_a    = rest_ff;
            mul_b    = NOTE_RECIP[idx_ff];
            quot_in  = prod[RECIP_SHIFT +: QUOT_W];
            state_in = ST_SPL_SUB;
         end
         ST_SPL_SUB: begin
            mul_a           = AMT_W'(take_n);
            mul_b           = RECIP_W'(NOTE_VALUE[idx_ff]);
            rest_in         = rest_next;
            take_in[idx_ff] = take_n;
            if (idx_ff == '0) begin
               if (rest_next == '0) begin
                  state_in = ST_DEBIT;
               end else begin
                  status_in = STAT_NO_COMPOSE;
                  state_in  = ST_FINISH;
               end
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_SPL_DIV;
            end
         end
         ST_DEBIT: begin
            for (int i = 0; i < NUM_DENOMS; i++) begin
               stock_in[i] = stock_ff[i] - take_ff[i];
            end
            status_in = STAT_DISPENSED;
            idx_in    = '0;
            acc_in    = '0;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            mul_a  = AMT_W'(stock_ff[idx_ff]);
            mul_b  = RECIP_W'(NOTE_VALUE[idx_ff]);
            acc_in = acc_sum;
            if (idx_ff == IDX_W'(NUM_DENOMS - 1)) begin
               total_in = (acc_sum > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                        : acc_sum[AMT_W-1:0];
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in.status      = status_ff;
               rsp_in.give_5000   = dispensed ? take_ff[5] : '0;
               rsp_in.give_2000   = dispensed ? take_ff[4] : '0;
               rsp_in.give_1000   = dispensed ? take_ff[3] : '0;
               rsp_in.give_500    = dispensed ? take_ff[2] : '0;
               rsp_in.give_200    = dispensed ? take_ff[1] : '0;
               rsp_in.give_100    = dispensed ? take_ff[0] : '0;
               rsp_in.total_after = total_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      amount_ff <= amount_in;
      rest_ff   <= rest_in;
      quot_ff   <= quot_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      take_ff   <= take_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int i = 0; i < NUM_DENOMS; i++) begin
            stock_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         stock_ff     <= stock_in;
      end
   end

   // No note count can rise above the cap, neither by load nor by a debit
   // that wraps below zero.
   assert property (@(posedge clock) disable iff (reset)
      ({6'b0, stock_ff[0]} <= MAX_NOTES) && ({6'b0, stock_ff[1]} <= MAX_NOTES) &&
      ({6'b0, stock_ff[2]} <= MAX_NOTES) && ({6'b0, stock_ff[3]} <= MAX_NOTES) &&
      ({6'b0, stock_ff[4]} <= MAX_NOTES) && ({6'b0, stock_ff[5]} <= MAX_NOTES))
      else $error("note count above the cap");

   // The value taken in one greedy step never exceeds what is left.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPL_SUB) |-> (prod[AMT_W-1:0] <= rest_ff))
      else $error("greedy step takes more than the remaining amount");

   // A dispensed response only follows an exact split.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == STAT_DISPENSED) |-> (rest_ff == '0))
      else $error("dispense reported with a remainder left");

   // An accepted beat always starts work; the block is busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != ST_IDLE))
      else $error("accepted request beat was not taken up");

endmodule
